// ===== design/ceq_pkg.sv =====
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared types and constants of the click event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

  localparam int CLICK_ID_W = 16;
  localparam int GEN_W      = 16;
  localparam int SETTING_W  = 8;
  localparam int TIME_W     = 32;
  localparam int PAIR_W     = 32;
  localparam int AGE_W      = 16;
  localparam int DROP_W     = 32;
  localparam int FILL_W     = 4;
  localparam int RUN_W      = 2;

  localparam logic [RUN_W-1:0] ST_READY    = 2'd0;
  localparam logic [RUN_W-1:0] ST_FAULT    = 2'd1;
  localparam logic [RUN_W-1:0] ST_NOTREADY = 2'd2;

  localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_POP    = 2'd1,
    OP_STATE  = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef struct packed {
    logic [CLICK_ID_W-1:0] evt_id;
    logic [GEN_W-1:0]      generation;
    logic [SETTING_W-1:0]  setting;
    logic                  is_release;
    logic [TIME_W-1:0]     time_ms;
    logic [PAIR_W-1:0]     pair;
  } slot_t;

endpackage

// ===== design/ceq_slot_ram.sv =====
// ----------------------------------------------------------------------------
// ceq_slot_ram
// Event slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ceq_slot_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  ceq_pkg::slot_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output ceq_pkg::slot_t      rd_data
);
  import ceq_pkg::*;

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/click_event_queue.sv =====
// Button, set state and cancel words give their registered result in the cycle after start.
// A pop reads the head slot, then checks the entries in turn, skipping stale ones, until it
// returns an event, drops an aged entry and flushes the queue, or has skipped every entry.
// Busy is high while a pop walks the queue, so no new word is taken until the pop is done.
// Synchronous active-low reset initialises all control state; slot memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// click_event_queue
// Ring queue of button press and release events with generation tracking.
// ----------------------------------------------------------------------------
module click_event_queue #(
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic                                in_button_down,
  input  logic [ceq_pkg::SETTING_W-1:0]       in_setting,
  input  logic                                in_pair_ok,
  input  logic [ceq_pkg::PAIR_W-1:0]          in_pair_data,
  input  logic [ceq_pkg::TIME_W-1:0]          in_now_ms,
  input  logic [ceq_pkg::RUN_W-1:0]           in_new_state,
  input  logic                                cfg_we,
  input  logic [ceq_pkg::AGE_W-1:0]           cfg_wdata,
  output logic                                out_strobe,
  output logic                                out_event_valid,
  output logic [ceq_pkg::CLICK_ID_W-1:0]      out_evt_id,
  output logic [ceq_pkg::GEN_W-1:0]           out_event_generation,
  output logic [ceq_pkg::TIME_W-1:0]          out_event_time_ms,
  output logic [ceq_pkg::PAIR_W-1:0]          out_event_pair,
  output logic [ceq_pkg::SETTING_W-1:0]       out_event_setting,
  output logic                                out_is_release,
  output logic [ceq_pkg::GEN_W-1:0]           out_current_generation,
  output logic [ceq_pkg::DROP_W-1:0]          out_dropped_count,
  output logic [ceq_pkg::FILL_W-1:0]          out_queue_fill
);
  import ceq_pkg::*;

  localparam int HeadW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IdW   = (ID_BITS > CLICK_ID_W) ? ID_BITS : CLICK_ID_W;

  typedef enum logic {S_IDLE, S_CHECK} fsm_t;

  fsm_t                  state_r, state_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [HeadW-1:0]      head_r, head_nxt;
  logic [CntW-1:0]       count_r, count_nxt;
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic [ID_BITS-1:0]    pending_r, pending_nxt;
  logic [CLICK_ID_W-1:0] active_r, active_nxt;
  logic [ID_BITS-1:0]    last_r, last_nxt;
  logic                  level_r, level_nxt;
  logic                  blocked_r, blocked_nxt;
  logic [SETTING_W-1:0]  hset_r, hset_nxt;
  logic [PAIR_W-1:0]     hpair_r, hpair_nxt;
  logic [DROP_W-1:0]     drop_r, drop_nxt;
  logic [AGE_W-1:0]      max_age_r;
  logic [TIME_W-1:0]     now_r, now_nxt;
  logic                  strobe_r, strobe_nxt;
  logic                  evv_r, evv_nxt;
  slot_t                 ev_r, ev_nxt;

  logic                  accept;
  op_t                   op;
  logic                  cancel_req, drop_inc, push_req;
  slot_t                 push_slot;
  logic [ID_BITS-1:0]    last_inc;
  logic [IdW-1:0]        id_ext;
  logic [CntW:0]         tail_sum;
  logic [HeadW-1:0]      tail;
  logic [HeadW-1:0]      head_inc;
  logic [CntW-1:0]       count_dec;
  logic [TIME_W-1:0]     age;

  logic                  ram_we, ram_re;
  logic [HeadW-1:0]      ram_raddr;
  slot_t                 ram_rdata;

  ceq_slot_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (HeadW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (tail),
    .wr_data (push_slot),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign op     = op_t'(in_operation);

  assign tail_sum  = (CntW + 1)'(head_r) + (CntW + 1)'(count_r);
  assign tail      = (tail_sum >= (CntW + 1)'(QUEUE_DEPTH))
                     ? HeadW'(tail_sum - (CntW + 1)'(QUEUE_DEPTH)) : HeadW'(tail_sum);
  assign head_inc  = (head_r == HeadW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign count_dec = count_r - 1'b1;
  assign age       = now_r - ram_rdata.time_ms;
  assign last_inc  = (last_r + 1'b1 == '0) ? ID_BITS'(1) : last_r + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    run_nxt     = run_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    gen_nxt     = gen_r;
    pending_nxt = pending_r;
    active_nxt  = active_r;
    last_nxt    = last_r;
    level_nxt   = level_r;
    blocked_nxt = blocked_r;
    hset_nxt    = hset_r;
    hpair_nxt   = hpair_r;
    drop_nxt    = drop_r;
    now_nxt     = now_r;
    strobe_nxt  = 1'b0;
    evv_nxt     = 1'b0;
    ev_nxt      = '0;
    cancel_req  = 1'b0;
    drop_inc    = 1'b0;
    push_req    = 1'b0;
    push_slot   = '0;
    id_ext      = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_r;

    if (state_r == S_IDLE) begin
      if (accept) begin
        case (op)
          OP_BUTTON: begin
            strobe_nxt = 1'b1;
            if (level_r != in_button_down) begin
              level_nxt = in_button_down;
              if (blocked_r || run_r != ST_READY) begin
                blocked_nxt = in_button_down;
                pending_nxt = '0;
              end else if (in_button_down) begin
                hpair_nxt = in_pair_data;
                if (!in_pair_ok) begin
                  pending_nxt = '0;
                end else begin
                  last_nxt    = last_inc;
                  pending_nxt = last_inc;
                  hset_nxt    = in_setting;
                  id_ext      = IdW'(last_inc);
                  push_req    = 1'b1;
                  push_slot.evt_id     = id_ext[CLICK_ID_W-1:0];
                  push_slot.setting    = in_setting;
                  push_slot.pair       = in_pair_data;
                  push_slot.is_release = 1'b0;
                end
              end else if (pending_r != '0) begin
                id_ext   = IdW'(pending_r);
                push_req = 1'b1;
                push_slot.evt_id     = id_ext[CLICK_ID_W-1:0];
                push_slot.setting    = hset_r;
                push_slot.pair       = hpair_r;
                push_slot.is_release = 1'b1;
              end
            end
          end
          OP_POP: begin
            now_nxt = in_now_ms;
            if (run_r == ST_READY && count_r != '0) begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_CHECK;
            end else begin
              strobe_nxt = 1'b1;
            end
          end
          OP_STATE: begin
            strobe_nxt = 1'b1;
            if (run_r != ST_FAULT && run_r != in_new_state) begin
              cancel_req = 1'b1;
              run_nxt    = in_new_state;
            end
          end
          default: begin
            strobe_nxt = 1'b1;
            cancel_req = 1'b1;
          end
        endcase
      end
    end else begin
      head_nxt  = head_inc;
      count_nxt = count_dec;
      if (age > TIME_W'(max_age_r)) begin
        drop_inc   = 1'b1;
        cancel_req = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end else if (ram_rdata.generation != gen_r ||
                   (ram_rdata.is_release && active_r != ram_rdata.evt_id)) begin
        if (count_dec == '0) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_inc;
        end
      end else begin
        active_nxt = ram_rdata.is_release ? '0 : ram_rdata.evt_id;
        strobe_nxt = 1'b1;
        evv_nxt    = 1'b1;
        ev_nxt     = ram_rdata;
        state_nxt  = S_IDLE;
      end
    end

    push_slot.generation = gen_r;
    push_slot.time_ms    = in_now_ms;

    if (push_req) begin
      if (count_r >= CntW'(QUEUE_DEPTH)) begin
        drop_inc   = 1'b1;
        cancel_req = 1'b1;
      end else begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        if (push_slot.is_release) begin
          pending_nxt = '0;
        end
      end
    end

    if (drop_inc) begin
      drop_nxt = drop_r + 1'b1;
    end

    if (cancel_req) begin
      head_nxt    = '0;
      count_nxt   = '0;
      gen_nxt     = gen_r + 1'b1;
      pending_nxt = '0;
      active_nxt  = '0;
      blocked_nxt = level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      run_r     <= ST_NOTREADY;
      head_r    <= '0;
      count_r   <= '0;
      gen_r     <= '0;
      pending_r <= '0;
      active_r  <= '0;
      last_r    <= '0;
      level_r   <= 1'b0;
      blocked_r <= 1'b0;
      hset_r    <= '0;
      hpair_r   <= '0;
      drop_r    <= '0;
      max_age_r <= MAX_AGE_RESET;
      now_r     <= '0;
      strobe_r  <= 1'b0;
      evv_r     <= 1'b0;
      ev_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      run_r     <= run_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      gen_r     <= gen_nxt;
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      last_r    <= last_nxt;
      level_r   <= level_nxt;
      blocked_r <= blocked_nxt;
      hset_r    <= hset_nxt;
      hpair_r   <= hpair_nxt;
      drop_r    <= drop_nxt;
      now_r     <= now_nxt;
      strobe_r  <= strobe_nxt;
      evv_r     <= evv_nxt;
      ev_r      <= ev_nxt;
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
    end
  end

  assign out_strobe             = strobe_r;
  assign out_event_valid        = evv_r;
  assign out_evt_id             = ev_r.evt_id;
  assign out_event_generation   = ev_r.generation;
  assign out_event_time_ms      = ev_r.time_ms;
  assign out_event_pair         = ev_r.pair;
  assign out_event_setting      = ev_r.setting;
  assign out_is_release         = ev_r.is_release;
  assign out_current_generation = gen_r;
  assign out_dropped_count      = drop_r;
  assign out_queue_fill         = FILL_W'(count_r);

endmodule
